### rtl/corrected_matrix_trace_hsnorm_core_assert.svh
// assertion macros for the corrected matrix trace and norm core
// depends on clk and rst_n being present in the including module
`ifndef CORRECTED_MATRIX_TRACE_HSNORM_CORE_ASSERT_SVH
`define CORRECTED_MATRIX_TRACE_HSNORM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CMTH_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cmth assertion failed");
`define CMTH_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmth implication failed");
`else
`define CMTH_ASSERT(name, prop)
`define CMTH_ASSERT_IMPL(name, ante, cons)
`endif
`endif

### rtl/cmth_pkg.sv
// shared types and constants for the corrected matrix trace and norm core
// no dependencies
`timescale 1ns / 1ps
package cmth_pkg;
    localparam int MAX_TERMS_DEF = 64;
    localparam int MAX_ROWS_DEF  = 256;
    localparam int MAX_COLS_DEF  = 1024;

    localparam logic [2:0] ACT_LOAD_TX = 3'd0;
    localparam logic [2:0] ACT_LOAD_TQ = 3'd1;
    localparam logic [2:0] ACT_LOAD_J  = 3'd2;
    localparam logic [2:0] ACT_ENTRY   = 3'd3;
    localparam logic [2:0] ACT_CLEAR   = 3'd4;

    localparam logic [1:0] REG_INNER_LENGTH  = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT     = 2'd1;
    localparam logic [1:0] REG_COLUMN_OFFSET = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_SAT,
        S_SQ,
        S_ACC
    } state_t;

    typedef struct packed {
        logic start;
        logic rd_valid;
    } mac_ctl_t;
endpackage

### rtl/cmth_ram.sv
// generic synchronous ram, one write port, two registered read ports
// no dependencies
`timescale 1ns / 1ps
module cmth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

### rtl/cmth_mac.sv
// product and accumulate unit: two products per term, floor shift, 64 bit sum
// depends on cmth_pkg
`timescale 1ns / 1ps
module cmth_mac
    import cmth_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mac_ctl_t           ctl,
    input  logic signed [31:0] m,
    input  logic signed [31:0] x,
    input  logic signed [31:0] qi,
    input  logic signed [31:0] qj,
    input  logic signed [31:0] jj,
    output logic signed [63:0] acc,
    output logic               busy
);
    logic signed [63:0] pa_reg;
    logic signed [63:0] pb_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] diff;
    logic               pr_v_reg;

    assign diff = pa_reg - pb_reg;
    assign acc  = acc_reg;
    assign busy = pr_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_v_reg <= 1'b0;
        end
        else
        begin
            pr_v_reg <= ctl.rd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_valid)
        begin
            pa_reg <= 64'(x) * 64'(qj);
            pb_reg <= 64'(qi) * 64'(jj);
        end
        if (ctl.start)
        begin
            acc_reg <= 64'(m);
        end
        else if (pr_v_reg)
        begin
            acc_reg <= acc_reg + (diff >>> 16);
        end
    end
endmodule

### rtl/corrected_matrix_trace_hsnorm_core.sv
// corrected matrix entry, trace and squared norm core, top level
// depends on cmth_pkg, cmth_ram, cmth_mac and the assertion macro header
//
// channel  direction  handshake            payload
// in       into core  in_valid / in_stall  action term_index row_index col_index value
// out      from core  out_valid/out_stall  entry_value is_diagonal trace_total
//                                          hsnorm_total index_error
// cfg      into core  cfg_valid/cfg_ready  cfg_index cfg_data
//
// loads and clears complete in the cycle they are accepted; an entry makes min(inner_length, MAX_TERMS)
// reads of the term memories, one per cycle, then drain, saturate, square and accumulate
// (inner_length 0 skips the reads, a rejected entry goes straight to accumulate)
// no clearing pass after reset: stores hold no valid state
// the core runs one item at a time; only the final accumulate waits on out_stall
`timescale 1ns / 1ps
`include "corrected_matrix_trace_hsnorm_core_assert.svh"
module corrected_matrix_trace_hsnorm_core
    import cmth_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_COLS  = MAX_COLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic [5:0]         term_index,
    input  logic [7:0]         row_index,
    input  logic [9:0]         col_index,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] entry_value,
    output logic               is_diagonal,
    output logic signed [63:0] trace_total,
    output logic [63:0]        hsnorm_total,
    output logic               index_error,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    localparam int TW  = $clog2(MAX_TERMS + 1);
    localparam int XD  = MAX_TERMS * MAX_ROWS;
    localparam int QD  = MAX_TERMS * MAX_COLS;
    localparam int XAW = (XD > 1) ? $clog2(XD) : 1;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;

    state_t state_reg, state_next;

    logic [6:0]  inner_length_reg;
    logic [8:0]  row_count_reg;
    logic [9:0]  column_offset_reg;

    logic [TW-1:0]  terms_reg;
    logic [TW-1:0]  term_reg, term_next;
    logic [XAW-1:0] base_x_reg;
    logic [QAW-1:0] base_qi_reg;
    logic [QAW-1:0] base_qj_reg;
    logic        diag_reg;
    logic        bad_reg;
    logic        rd_v_reg;
    logic signed [31:0] e_reg;
    logic [63:0] sq_reg;

    logic signed [63:0] trace_acc_reg;
    logic [63:0]        hsnorm_acc_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_e_reg;
    logic               out_diag_reg;
    logic signed [63:0] out_trace_reg;
    logic [63:0]        out_norm_reg;
    logic               out_err_reg;

    logic        accept;
    logic        issue;
    logic        out_free;
    logic [31:0] jcol;
    logic        bad;
    logic [TW-1:0] terms;
    logic [31:0] ld_addr;
    logic        ld_ok_x;
    logic        ld_ok_q;
    logic        we_x, we_q, we_j;
    logic [XAW-1:0] rx_addr;
    logic [QAW-1:0] rqi_addr, rqj_addr;
    logic [31:0] x_d, qi_d, qj_d, j_d, x_unused, j_unused;
    mac_ctl_t    mac_ctl;
    logic signed [63:0] mac_acc;
    logic        mac_busy;
    logic [64:0] norm_sum;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign issue     = (state_reg == S_RUN);
    assign out_free  = !out_valid_reg || !out_stall;

    assign jcol = 32'(column_offset_reg) + 32'(col_index);
    assign bad  = (32'(row_index) >= 32'(row_count_reg)) || (32'(row_index) >= 32'(MAX_ROWS))
               || (32'(row_index) >= 32'(MAX_COLS)) || (jcol >= 32'(MAX_COLS));
    assign terms = (32'(inner_length_reg) > 32'(MAX_TERMS)) ? TW'(MAX_TERMS)
                                                            : TW'(inner_length_reg);

    assign ld_addr = 32'(term_index) + 32'(col_index) * 32'(MAX_TERMS);
    assign ld_ok_x = (32'(term_index) < 32'(MAX_TERMS)) && (32'(col_index) < 32'(MAX_ROWS));
    assign ld_ok_q = (32'(term_index) < 32'(MAX_TERMS)) && (32'(col_index) < 32'(MAX_COLS));
    assign we_x = accept && (action == ACT_LOAD_TX) && ld_ok_x;
    assign we_q = accept && (action == ACT_LOAD_TQ) && ld_ok_q;
    assign we_j = accept && (action == ACT_LOAD_J) && ld_ok_q;

    assign rx_addr  = base_x_reg + XAW'(term_reg);
    assign rqi_addr = base_qi_reg + QAW'(term_reg);
    assign rqj_addr = base_qj_reg + QAW'(term_reg);

    cmth_ram #(.WIDTH(32), .DEPTH(XD)) u_tx_ram (
        .clk(clk), .we(we_x), .waddr(XAW'(ld_addr)), .wdata(value),
        .raddr_a(rx_addr), .rdata_a(x_d), .raddr_b(rx_addr), .rdata_b(x_unused)
    );
    cmth_ram #(.WIDTH(32), .DEPTH(QD)) u_tq_ram (
        .clk(clk), .we(we_q), .waddr(QAW'(ld_addr)), .wdata(value),
        .raddr_a(rqi_addr), .rdata_a(qi_d), .raddr_b(rqj_addr), .rdata_b(qj_d)
    );
    cmth_ram #(.WIDTH(32), .DEPTH(QD)) u_j_ram (
        .clk(clk), .we(we_j), .waddr(QAW'(ld_addr)), .wdata(value),
        .raddr_a(rqj_addr), .rdata_a(j_d), .raddr_b(rqj_addr), .rdata_b(j_unused)
    );

    assign mac_ctl.start    = accept && (action == ACT_ENTRY);
    assign mac_ctl.rd_valid = rd_v_reg;

    cmth_mac u_mac (
        .clk(clk), .rst_n(rst_n), .ctl(mac_ctl), .m(value),
        .x(x_d), .qi(qi_d), .qj(qj_d), .jj(j_d),
        .acc(mac_acc), .busy(mac_busy)
    );

    assign norm_sum = {1'b0, hsnorm_acc_reg} + {1'b0, sq_reg};

    assign out_valid    = out_valid_reg;
    assign entry_value  = out_e_reg;
    assign is_diagonal  = out_diag_reg;
    assign trace_total  = out_trace_reg;
    assign hsnorm_total = out_norm_reg;
    assign index_error  = out_err_reg;

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                term_next = '0;
                if (accept && (action == ACT_ENTRY))
                begin
                    if (bad)
                        state_next = S_ACC;
                    else if (terms == '0)
                        state_next = S_SAT;
                    else
                        state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                term_next = term_reg + 1'b1;
                if (term_reg == terms_reg - 1'b1)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!rd_v_reg && !mac_busy)
                    state_next = S_SAT;
            end
            S_SAT:
            begin
                state_next = S_SQ;
            end
            S_SQ:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            term_reg          <= '0;
            rd_v_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
            inner_length_reg  <= 7'd1;
            row_count_reg     <= 9'd1;
            column_offset_reg <= 10'd0;
            trace_acc_reg     <= '0;
            hsnorm_acc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            rd_v_reg  <= issue;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_INNER_LENGTH:  inner_length_reg  <= cfg_data[6:0];
                    REG_ROW_COUNT:     row_count_reg     <= cfg_data[8:0];
                    REG_COLUMN_OFFSET: column_offset_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (accept && (action == ACT_CLEAR))
            begin
                trace_acc_reg  <= '0;
                hsnorm_acc_reg <= '0;
            end
            if ((state_reg == S_ACC) && out_free)
            begin
                out_valid_reg  <= 1'b1;
                hsnorm_acc_reg <= norm_sum[64] ? '1 : norm_sum[63:0];
                if (diag_reg)
                    trace_acc_reg <= trace_acc_reg + 64'(e_reg);
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (action == ACT_ENTRY))
        begin
            terms_reg   <= terms;
            bad_reg     <= bad;
            diag_reg    <= !bad && (10'(row_index) == col_index);
            base_x_reg  <= XAW'(32'(row_index) * 32'(MAX_TERMS));
            base_qi_reg <= QAW'(32'(row_index) * 32'(MAX_TERMS));
            base_qj_reg <= QAW'(jcol * 32'(MAX_TERMS));
            e_reg       <= '0;
            sq_reg      <= '0;
        end
        if (state_reg == S_SAT)
        begin
            if (mac_acc > 64'sd2147483647)
                e_reg <= 32'sh7fffffff;
            else if (mac_acc < -64'sd2147483648)
                e_reg <= 32'sh80000000;
            else
                e_reg <= mac_acc[31:0];
        end
        if (state_reg == S_SQ)
            sq_reg <= 64'(64'(e_reg) * 64'(e_reg));
        if ((state_reg == S_ACC) && out_free)
        begin
            out_e_reg     <= e_reg;
            out_diag_reg  <= diag_reg;
            out_err_reg   <= bad_reg;
            out_norm_reg  <= norm_sum[64] ? '1 : norm_sum[63:0];
            out_trace_reg <= diag_reg ? trace_acc_reg + 64'(e_reg) : trace_acc_reg;
        end
    end

    `CMTH_ASSERT_IMPL(a_take_only_idle, !in_stall, state_reg == S_IDLE)
    `CMTH_ASSERT_IMPL(a_bad_entry_zero, out_valid && index_error, entry_value == 0 && !is_diagonal)
    `CMTH_ASSERT_IMPL(a_term_in_range, state_reg == S_RUN, term_reg < terms_reg)
    `CMTH_ASSERT_IMPL(a_no_read_when_idle, state_reg == S_IDLE, !rd_v_reg && !mac_busy)
endmodule
